>>> design/sbps_pkg.sv
package sbps_pkg;

  // fixed field widths
  localparam int BONE_W      = 9;
  localparam int VIDX_W      = 16;
  localparam int LB_W        = 7;
  localparam int PBONE_W     = 8;
  localparam int NUM_BONES   = 4;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;

  // local bone code for "no bone"
  localparam logic [LB_W-1:0] LB_NONE = 7'h7F;

  // batch closes at a triangle end when count + CLOSE_MARGIN reaches the limit
  localparam int CLOSE_MARGIN = 3;

  // palette lookup lanes
  localparam int NUM_LANES   = 8;
  localparam int LANE_OFF_W  = 3;

  // parameter defaults
  localparam int PALETTE_LIMIT_DEF     = 48;
  localparam int SKELETON_BITS_DEF     = 8;
  localparam int VERTEX_INDEX_BITS_DEF = 16;

  // result kinds
  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // what one lane found
  typedef struct packed {
    logic                  hit;
    logic [LANE_OFF_W-1:0] offset;
  } lane_hit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_VERTEX,
    ST_PAL_READ,
    ST_PAL_OUT
  } state_t;

endpackage

>>> design/sbps_lane.sv
module sbps_lane import sbps_pkg::*; #(
  parameter int EPL   = 7,
  parameter int KEY_W = 8
) (
  input  logic [EPL-1:0][KEY_W-1:0] entries,
  input  logic [EPL-1:0]            valid,
  input  logic [KEY_W-1:0]          key,
  output lane_hit_t                 result
);

  // compare the key against this lane's entries; live entries are distinct
  always_comb begin
    result = '0;
    for (int e = 0; e < EPL; e++) begin
      if (valid[e] && (entries[e] == key)) begin
        result.hit    = 1'b1;
        result.offset = result.offset | LANE_OFF_W'(e);
      end
    end
  end

endmodule

>>> design/sbps_merge.sv
module sbps_merge import sbps_pkg::*; #(
  parameter int EPL   = 7,
  parameter int IDX_W = 6
) (
  input  lane_hit_t [NUM_LANES-1:0] lanes,
  output logic                      hit,
  output logic [IDX_W-1:0]          idx
);

  // at most one lane hits, so the positions can be or-ed together
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (lanes[l].hit) begin
        hit = 1'b1;
        idx = idx | IDX_W'(l * EPL + int'(lanes[l].offset));
      end
    end
  end

endmodule

>>> design/skinned_mesh_bone_palette_splitter_top.sv
// channel   direction  tdata fields (low bit up)                        tuser         tlast
// s_*       in         bone_0[8:0] bone_1[17:9] bone_2[26:18]            triangle_end  stream_end
//                      bone_3[35:27], zero pad
// m_*       out        vertex_index[15:0] local_bone_0..3[22:16..43:37]  result_kind   last_of_run
//                      palette_bone[51:44], zero pad
//
// a vertex is accepted in the idle state, then gets one palette lookup per bone slot
// through the lane compare and merge, then the vertex transaction is loaded
// a batch close emits each palette entry by an emission memory read, then an output load
// reset clears the batch; the palette needs no clearing pass
// a stalled output holds the block in its current step; the input is taken only when idle
module skinned_mesh_bone_palette_splitter_top import sbps_pkg::*; #(
  parameter int PALETTE_LIMIT     = PALETTE_LIMIT_DEF,
  parameter int SKELETON_BITS     = SKELETON_BITS_DEF,
  parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // bone_0, bone_1, bone_2, bone_3, pad
  input  logic                  s_tuser,   // triangle_end
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // vertex_index, local_bone_0..3, palette_bone, pad
  output logic                  m_tuser,   // result_kind
  output logic                  m_tlast
);

  localparam int DEPTH     = PALETTE_LIMIT + 8;
  localparam int EPL       = (DEPTH + NUM_LANES - 1) / NUM_LANES;
  localparam int PAD_DEPTH = EPL * NUM_LANES;
  localparam int IDX_W     = $clog2(PAD_DEPTH);
  localparam int MEM_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int STORE_W   = (SKELETON_BITS < 8) ? SKELETON_BITS : 8;
  localparam int VC_W      = (VERTEX_INDEX_BITS < VIDX_W) ? VERTEX_INDEX_BITS : VIDX_W;

  state_t state, state_next;

  logic [1:0]                      slot;
  logic [NUM_BONES-1:0][BONE_W-1:0] bones;
  logic                            tri_end;
  logic                            strm_end;
  logic [NUM_BONES-1:0][LB_W-1:0]  local_bone;
  logic [VIDX_W-1:0]               vidx;
  logic [CNT_W-1:0]                count;
  logic [VC_W-1:0]                 vcount;
  logic [MEM_W-1:0]                rd_idx;
  logic [STORE_W-1:0]              rd_data;

  logic [PAD_DEPTH-1:0][STORE_W-1:0] store;
  logic [STORE_W-1:0]                mem [DEPTH];
  logic [PAD_DEPTH-1:0]              valid_vec;

  // fsm outputs
  logic in_ready, lookup_en, vtx_step, pal_step;

  // lookup of the current bone slot
  logic [BONE_W-1:0]  cur_bone;
  logic [7:0]         cur_val;
  logic               bone_ok;
  logic [STORE_W-1:0] key;
  logic               can_append;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  lane_hit_t [NUM_LANES-1:0] lane_res;

  logic out_free, close_now, pal_last, accept;

  assign accept   = s_tvalid && in_ready;
  assign s_tready = in_ready;
  assign out_free = !m_tvalid || m_tready;

  // current slot decode
  always_comb begin
    cur_bone   = bones[slot];
    cur_val    = cur_bone[7:0];
    bone_ok    = !cur_bone[BONE_W-1] && ((cur_val >> SKELETON_BITS) == 8'd0);
    key        = cur_val[STORE_W-1:0];
    can_append = (count < CNT_W'(DEPTH));
  end

  // live entries of the palette
  always_comb begin
    for (int i = 0; i < PAD_DEPTH; i++) begin
      valid_vec[i] = (8'(count) > 8'(i));
    end
  end

  // parallel compare lanes
  for (genvar l = 0; l < NUM_LANES; l++) begin : gen_lane
    sbps_lane #(
      .EPL   (EPL),
      .KEY_W (STORE_W)
    ) u_lane (
      .entries (store[l*EPL +: EPL]),
      .valid   (valid_vec[l*EPL +: EPL]),
      .key     (key),
      .result  (lane_res[l])
    );
  end

  sbps_merge #(
    .EPL   (EPL),
    .IDX_W (IDX_W)
  ) u_merge (
    .lanes (lane_res),
    .hit   (hit),
    .idx   (hit_idx)
  );

  // batch close test
  always_comb begin
    close_now = strm_end ||
                (tri_end && (((CNT_W+1)'(count) + (CNT_W+1)'(CLOSE_MARGIN)) >=
                             (CNT_W+1)'(PALETTE_LIMIT)));
    pal_last  = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (slot == 2'd3) state_next = ST_VERTEX;
      end
      ST_VERTEX: begin
        if (out_free) begin
          if (close_now && (count != '0)) state_next = ST_PAL_READ;
          else                            state_next = ST_IDLE;
        end
      end
      ST_PAL_READ: state_next = ST_PAL_OUT;
      ST_PAL_OUT: begin
        if (out_free) begin
          if (pal_last) state_next = ST_IDLE;
          else          state_next = ST_PAL_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    lookup_en = 1'b0;
    vtx_step  = 1'b0;
    pal_step  = 1'b0;
    case (state)
      ST_IDLE:     in_ready  = 1'b1;
      ST_LOOKUP:   lookup_en = 1'b1;
      ST_VERTEX:   vtx_step  = out_free;
      ST_PAL_READ: ;
      ST_PAL_OUT:  pal_step  = out_free;
      default:     ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      slot   <= '0;
      count  <= '0;
      vcount <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        slot <= '0;
        if (vcount != '1) vcount <= vcount + VC_W'(1);
      end else if (lookup_en) begin
        slot <= slot + 2'd1;
      end
      if (lookup_en && bone_ok && !hit && can_append) begin
        count <= count + CNT_W'(1);
      end
      if ((vtx_step && close_now && (count == '0)) || (pal_step && pal_last)) begin
        count  <= '0;
        vcount <= '0;
      end
    end
  end

  // input capture and lookup results
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < NUM_BONES; b++) begin
        bones[b] <= s_tdata[b*BONE_W +: BONE_W];
      end
      tri_end  <= s_tuser;
      strm_end <= s_tlast;
      vidx     <= VIDX_W'(vcount);
    end
    if (lookup_en) begin
      if (!bone_ok)        local_bone[slot] <= LB_NONE;
      else if (hit)        local_bone[slot] <= LB_W'(hit_idx);
      else if (can_append) local_bone[slot] <= LB_W'(count);
      else                 local_bone[slot] <= LB_NONE;
    end
  end

  // palette append into the compare store and the emission memory
  always_ff @(posedge clk) begin
    if (lookup_en && bone_ok && !hit && can_append) begin
      store[IDX_W'(count)] <= key;
      mem[MEM_W'(count)]   <= key;
    end
  end

  // emission read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (vtx_step) rd_idx <= '0;
    else if (pal_step) rd_idx <= rd_idx + MEM_W'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (vtx_step || pal_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_step) begin
      m_tdata <= {(OUT_DATA_W - VIDX_W - NUM_BONES*LB_W - PBONE_W)'(0),
                  PBONE_W'(0), local_bone, vidx};
      m_tuser <= KIND_VERTEX;
      m_tlast <= !(close_now && (count != '0));
    end else if (pal_step) begin
      m_tdata <= {(OUT_DATA_W - VIDX_W - NUM_BONES*LB_W - PBONE_W)'(0),
                  PBONE_W'(rd_data), {NUM_BONES{LB_NONE}}, VIDX_W'(0)};
      m_tuser <= KIND_PALETTE;
      m_tlast <= pal_last;
    end
  end

endmodule

>>> test/tb_skinned_mesh_bone_palette_splitter_top.sv
module tb_skinned_mesh_bone_palette_splitter_top;
  import sbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAL_DEPTH   = PALETTE_LIMIT_DEF + 8;
  localparam int unsigned VIDX_MAX    = (VERTEX_INDEX_BITS_DEF >= 16) ? 65535 :
                                        (1 << VERTEX_INDEX_BITS_DEF) - 1;
  localparam int          BONES_W     = NUM_BONES * BONE_W;
  localparam int          DRAIN_LIMIT = 200000;
  localparam int          MAX_PRINTS  = 40;

  // one vertex as it enters the block
  typedef struct packed {
    logic                               strm_end;
    logic                               tri_end;
    logic [NUM_BONES-1:0][BONE_W-1:0]   bone;
  } vertex_t;

  // one result transaction as it leaves the block
  typedef struct packed {
    logic                               kind;
    logic [VIDX_W-1:0]                  vidx;
    logic [NUM_BONES-1:0][LB_W-1:0]     lb;
    logic [PBONE_W-1:0]                 pbone;
    logic                               last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // bone_0, bone_1, bone_2, bone_3, pad
  logic                  s_tuser;   // triangle_end
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // vertex_index, local_bone_0..3, palette_bone, pad
  logic                  m_tuser;   // result_kind
  logic                  m_tlast;

  // palette model of the current batch
  logic [PBONE_W-1:0] pal_bones [PAL_DEPTH];
  int unsigned        pal_count    = 0;
  int unsigned        batch_vcount = 0;

  result_t expected_results [$];
  int      send_idle_pct = 30;
  int      recv_idle_pct = 57;
  int      stall_left    = 0;
  int      mismatches    = 0;
  int      n_sent        = 0;
  int      n_checked     = 0;

  skinned_mesh_bone_palette_splitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // append one expectation at the tail of the queue
  function automatic void add_expected(result_t e);
    expected_results.insert(expected_results.size(), e);
  endfunction

  // palette lookup, appending a new bone while there is room
  function automatic logic [LB_W-1:0] map_to_palette(logic [BONE_W-1:0] raw);
    int h;
    if (raw[BONE_W-1] || raw >= (1 << SKELETON_BITS_DEF))
      return LB_NONE;
    for (h = 0; h < pal_count; h++)
      if (pal_bones[h] == raw[PBONE_W-1:0])
        return LB_W'(h);
    if (pal_count >= PAL_DEPTH)
      return LB_NONE;
    pal_bones[pal_count] = raw[PBONE_W-1:0];
    h = pal_count;
    pal_count++;
    return LB_W'(h);
  endfunction

  // vertex result, then the palette dump when the batch closes
  function automatic void predict_vertex(vertex_t v);
    result_t r;
    result_t p;
    logic    close_now;
    int      h;
    r.kind  = KIND_VERTEX;
    r.vidx  = VIDX_W'(batch_vcount);
    for (h = 0; h < NUM_BONES; h++)
      r.lb[h] = map_to_palette(v.bone[h]);
    r.pbone = '0;
    r.last  = 1'b0;
    if (batch_vcount < VIDX_MAX)
      batch_vcount++;
    close_now = v.strm_end ||
                (v.tri_end && pal_count + CLOSE_MARGIN >= PALETTE_LIMIT_DEF);
    if (!close_now || pal_count == 0)
      r.last = 1'b1;
    add_expected(r);
    if (close_now) begin
      for (h = 0; h < pal_count; h++) begin
        p.kind  = KIND_PALETTE;
        p.vidx  = '0;
        p.lb    = {NUM_BONES{LB_NONE}};
        p.pbone = pal_bones[h];
        p.last  = (h == pal_count - 1);
        add_expected(p);
      end
      pal_count    = 0;
      batch_vcount = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h expected %0h (result %0d)",
               $realtime, what, got, want, n_checked);
  endtask

  // compare one result transaction against the oldest expectation
  task automatic check_result();
    result_t got;
    result_t want;
    int      j;
    got.kind  = m_tuser;
    got.vidx  = m_tdata[VIDX_W-1:0];
    got.lb    = m_tdata[VIDX_W +: NUM_BONES*LB_W];
    got.pbone = m_tdata[VIDX_W+NUM_BONES*LB_W +: PBONE_W];
    got.last  = m_tlast;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", got, 0);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind)
        report_mismatch("result_kind", got.kind, want.kind);
      if (got.vidx !== want.vidx)
        report_mismatch("vertex_index", got.vidx, want.vidx);
      for (j = 0; j < NUM_BONES; j++)
        if (got.lb[j] !== want.lb[j])
          report_mismatch($sformatf("local_bone_%0d", j), got.lb[j], want.lb[j]);
      if (got.pbone !== want.pbone)
        report_mismatch("palette_bone", got.pbone, want.pbone);
      if (got.last !== want.last)
        report_mismatch("last_of_run", got.last, want.last);
    end
    n_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      check_result();
  end

  // receiver: random ready, or a counted hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one vertex until the block takes it
  task automatic send_vertex(vertex_t v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_DATA_W-BONES_W){1'b0}}, v.bone};
    s_tuser  = v.tri_end;
    s_tlast  = v.strm_end;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    predict_vertex(v);
    n_sent++;
  endtask

  // sender pauses until every expected result is back
  task automatic wait_for_results(int settle);
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch("results never arrived", expected_results.size(), 0);
      expected_results.delete();
    end
    repeat (settle) @(negedge clk);
  endtask

  function automatic vertex_t make_vertex(int b0, int b1, int b2, int b3,
                                          bit te, bit se);
    vertex_t v;
    v.bone[0]  = b0[BONE_W-1:0];
    v.bone[1]  = b1[BONE_W-1:0];
    v.bone[2]  = b2[BONE_W-1:0];
    v.bone[3]  = b3[BONE_W-1:0];
    v.tri_end  = te;
    v.strm_end = se;
    return v;
  endfunction

  // bone drawn around the current mesh's skeleton range, with none and odd negatives
  function automatic logic [BONE_W-1:0] pick_bone(int base, int span);
    int r;
    r = $urandom_range(99);
    if (r < 15)
      return '1;
    if (r < 19)
      return {1'b1, 8'($urandom_range(255))};
    return BONE_W'((base + $urandom_range(span)) % 256);
  endfunction

  // empty palette close, extremes of bone values, repeats, both end marks
  task automatic test_end_marks();
    send_vertex(make_vertex(-1, -1, -1, -1, 1'b0, 1'b1));
    send_vertex(make_vertex(0, 255, -1, -256, 1'b0, 1'b0));
    send_vertex(make_vertex(255, 255, 0, -2, 1'b1, 1'b0));
    send_vertex(make_vertex(7, 8, 9, 7, 1'b1, 1'b1));
    wait_for_results(10);
  endtask

  // triangle close just below and at the threshold
  task automatic test_close_threshold();
    int k;
    for (k = 0; k < 11; k++)
      send_vertex(make_vertex(4*k, 4*k+1, 4*k+2, 4*k+3, (k % 3 == 2) || k == 10, 1'b0));
    send_vertex(make_vertex(44, 0, -1, 1, 1'b1, 1'b0));
    wait_for_results(10);
  endtask

  // fill the whole store, then new bones find no room
  task automatic test_palette_overflow();
    int k;
    for (k = 0; k < PAL_DEPTH / 4; k++)
      send_vertex(make_vertex(100+4*k, 101+4*k, 102+4*k, 103+4*k, 1'b0, 1'b0));
    send_vertex(make_vertex(200, 100, 201, -1, 1'b0, 1'b0));
    send_vertex(make_vertex(155, 199, 0, 1, 1'b1, 1'b0));
    wait_for_results(10);
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_stall();
    int k;
    @(negedge clk);
    stall_left = 400;
    for (k = 0; k < 40; k++)
      send_vertex(make_vertex($urandom_range(40), $urandom_range(40), -1,
                              $urandom_range(40), (k % 3 == 2), k == 39));
    wait_for_results(10);
  endtask

  // mostly well-formed triangles of random meshes, some noise vertices
  task automatic test_random_meshes(int n_items);
    int      count;
    int      base;
    int      span;
    int      k;
    vertex_t v;
    count = 0;
    base  = $urandom_range(255);
    span  = 7;
    while (count < n_items) begin
      if ($urandom_range(9) == 0) begin
        for (k = 0; k < NUM_BONES; k++)
          v.bone[k] = BONE_W'($urandom_range(511));
        v.tri_end  = ($urandom_range(3) == 0);
        v.strm_end = ($urandom_range(15) == 0);
        send_vertex(v);
        count++;
      end else begin
        for (k = 0; k < 3; k++) begin
          v = make_vertex(pick_bone(base, span), pick_bone(base, span),
                          pick_bone(base, span), pick_bone(base, span),
                          k == 2, (k == 2) && ($urandom_range(24) == 0));
          send_vertex(v);
          count++;
          if (v.strm_end) begin
            base = $urandom_range(255);
            case ($urandom_range(3))
              0: span = 7;
              1: span = 31;
              2: span = 127;
              default: span = 255;
            endcase
          end
        end
      end
    end
    wait_for_results(10);
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_end_marks();
    test_close_threshold();
    test_palette_overflow();
    test_output_stall();

    send_idle_pct = 30;
    recv_idle_pct = 57;
    test_random_meshes(130);
    send_idle_pct = 57;
    recv_idle_pct = 30;
    test_random_meshes(130);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_meshes(130);

    wait_for_results(20);
    $display("ran %0d vertex transactions, checked %0d results", n_sent, n_checked);
    $display("covered empty and full palettes, close threshold, end marks, odd bones, stalls");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
